// ----- sv/sorted_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// concurrent check wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 16;
    localparam int STATUS_W     = 2;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [PRIO_W-1:0]  t_prio;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic   occ;
        t_value value;
        t_prio  prio;
    } t_cell_data;

    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_value value;
        t_prio  prio;
    } t_cell_ctl;

endpackage

// ----- sv/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_if
// valid/ready channels for command and result beats
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   cmd;
    t_value item_value;
    t_prio  item_priority;

    modport source (output valid, output cmd, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input cmd, input item_value, input item_priority,
                    output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                valid;
    logic                ready;
    t_value              out_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_value, output status, input ready);
    modport sink   (input valid, input out_value, input status, output ready);
endinterface

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: compare, keep, take from left or right
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_data i_left,
    input  logic       i_left_ins,
    input  t_cell_data i_right,
    output t_cell_data o_data,
    output logic       o_ins
);

    logic   r_occ;
    t_value r_value;
    t_prio  r_prio;
    logic   n_occ;
    t_value n_value;
    t_prio  n_prio;
    logic   ins_here;

    always_comb begin
        ins_here = !r_occ || ($signed(i_ctl.prio) <= $signed(r_prio));
        n_occ    = r_occ;
        n_value  = r_value;
        n_prio   = r_prio;
        if (i_ctl.ins_en) begin
            if (i_left_ins) begin
                n_occ   = i_left.occ;
                n_value = i_left.value;
                n_prio  = i_left.prio;
            end else if (ins_here) begin
                n_occ   = 1'b1;
                n_value = i_ctl.value;
                n_prio  = i_ctl.prio;
            end
        end else if (i_ctl.rem_en) begin
            n_occ   = i_right.occ;
            n_value = i_right.value;
            n_prio  = i_right.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

    assign o_data.occ   = r_occ;
    assign o_data.value = r_value;
    assign o_data.prio  = r_prio;
    assign o_ins        = ins_here;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue held as a sorted chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// Takes one command beat per clock and returns one result beat for each, in the
// cycle after acceptance, from a result register that frees itself as soon as
// the sink takes it; the input stalls only while that register is held. All
// CAPACITY cells compare the broadcast priority in the same cycle, so the cost
// of insert and remove does not grow with fill. An insert lands ahead of
// every stored entry of equal or larger priority; slot 0 is the head.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    t_cell_data          cell_data [CAPACITY];
    logic                cell_ins  [CAPACITY];
    logic [CAPACITY-1:0] occ_vec;
    t_cell_ctl           ctl;
    logic                accept;
    logic                full;
    logic                empty;
    logic                ins_full;
    logic                rem_ok;

    logic                r_out_valid;
    t_value              r_out_value;
    t_status             r_out_status;

    assign full     = occ_vec[CAPACITY-1];
    assign empty    = !occ_vec[0];
    assign accept   = i_in.valid && i_in.ready;
    assign ins_full = accept && (i_in.cmd == CMD_INSERT) && full;
    assign rem_ok   = accept && (i_in.cmd == CMD_REMOVE) && !empty;

    assign ctl.ins_en = accept && (i_in.cmd == CMD_INSERT) && !full;
    assign ctl.rem_en = rem_ok;
    assign ctl.value  = i_in.item_value;
    assign ctl.prio   = i_in.item_priority;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_data left_data;
            logic       left_ins;
            t_cell_data right_data;

            if (gi == 0) begin : g_head
                assign left_data = '0;
                assign left_ins  = 1'b0;
            end else begin : g_mid
                assign left_data = cell_data[gi-1];
                assign left_ins  = cell_ins[gi-1];
            end

            if (gi == CAPACITY-1) begin : g_tail
                assign right_data = '0;
            end else begin : g_body
                assign right_data = cell_data[gi+1];
            end

            spq_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_left     (left_data),
                .i_left_ins (left_ins),
                .i_right    (right_data),
                .o_data     (cell_data[gi]),
                .o_ins      (cell_ins[gi])
            );

            assign occ_vec[gi] = cell_data[gi].occ;
        end
    endgenerate

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value <= rem_ok ? cell_data[0].value : '0;
            if (i_in.cmd == CMD_INSERT) begin
                r_out_status <= full ? ST_FULL : ST_OK;
            end else begin
                r_out_status <= empty ? ST_EMPTY : ST_OK;
            end
        end
    end

    assign i_in.ready      = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.status    = r_out_status;

    `SPQ_ASSERT_SAME(a_occ_contiguous, i_clk, i_rst_n, 1'b1, ((occ_vec >> 1) & ~occ_vec) == '0, "occupied cells not contiguous from head")
    `SPQ_ASSERT_SAME(a_head_sorted, i_clk, i_rst_n, occ_vec[1], $signed(cell_data[0].prio) <= $signed(cell_data[1].prio), "head priority above its successor")
    `SPQ_ASSERT_NEXT(a_full_status, i_clk, i_rst_n, ins_full, o_out.valid && (o_out.status == ST_FULL), "refused insert not reported full")
    `SPQ_ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, rem_ok, $countones(occ_vec) == $countones($past(occ_vec)) - 1, "remove did not drop one entry")

endmodule
